@@ sv/vcq12_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcq12_pkg: shared types, constants and helpers for the Q12 vector cosine
// Transaction structs, controller states and the fixed widths of the datapath.
// ----------------------------------------------------------------------------
package vcq12_pkg;

    localparam int VEC_W      = 32;   // component and accumulator width
    localparam int LEN_W      = 6;    // bit length 1..32
    localparam int COMP_W     = 16;   // rescaled component width
    localparam int ROOT_W     = 16;   // square root width
    localparam int COS_W      = 14;   // Q12 cosine width
    localparam int TARGET_LEN = 14;   // rescaled bit length
    localparam int BAL_TOTAL  = 24;   // combined bit length of squared pair
    localparam int Q_SHIFT    = 12;   // Q12 fraction bits
    localparam int COS_ONE    = 4096; // 1.0 in Q12

    typedef struct packed {
        logic signed [VEC_W-1:0] first_x;
        logic signed [VEC_W-1:0] first_y;
        logic signed [VEC_W-1:0] first_z;
        logic signed [VEC_W-1:0] second_x;
        logic signed [VEC_W-1:0] second_y;
        logic signed [VEC_W-1:0] second_z;
    } vcq12_operand_t;

    typedef struct packed {
        logic signed [COS_W-1:0] cosine;
        logic                    zero_divisor;
    } vcq12_result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN1,
        ST_MUL,
        ST_SCAN2_GO,
        ST_SCAN2,
        ST_BAL,
        ST_SUM,
        ST_NPROD,
        ST_ROOT_GO,
        ST_SQRT,
        ST_DIV,
        ST_DONE
    } vcq12_state_t;

    // Two's complement magnitude; the most negative value maps to itself
    function automatic logic [VEC_W-1:0] mag32(input logic [VEC_W-1:0] v);
        return v[VEC_W-1] ? (VEC_W'(0) - v) : v;
    endfunction

endpackage

@@ sv/vcq12_bitlen.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcq12_bitlen: two-lane serial bit length scanner
// Shifts each word left one bit per cycle until its top bit is set; the
// length counts down from 32 and never drops below 1.
// ----------------------------------------------------------------------------
module vcq12_bitlen (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [vcq12_pkg::VEC_W-1:0]     word_a,
    input  logic [vcq12_pkg::VEC_W-1:0]     word_b,
    output logic                            done,
    output logic [vcq12_pkg::LEN_W-1:0]     len_a,
    output logic [vcq12_pkg::LEN_W-1:0]     len_b
);

    logic                            run_reg;
    logic [vcq12_pkg::VEC_W-1:0]     wa_reg;
    logic [vcq12_pkg::VEC_W-1:0]     wb_reg;
    logic [vcq12_pkg::LEN_W-1:0]     la_reg;
    logic [vcq12_pkg::LEN_W-1:0]     lb_reg;
    logic                            step_a;
    logic                            step_b;

    // Step while the top bit is clear and the length can still shrink
    assign step_a = !wa_reg[vcq12_pkg::VEC_W-1] && (la_reg > vcq12_pkg::LEN_W'(1));
    assign step_b = !wb_reg[vcq12_pkg::VEC_W-1] && (lb_reg > vcq12_pkg::LEN_W'(1));
    assign done   = run_reg && !step_a && !step_b;
    assign len_a  = la_reg;
    assign len_b  = lb_reg;

    // Hold the scan flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
        end
        else if (start)
        begin
            run_reg <= 1'b1;
        end
        else if (done)
        begin
            run_reg <= 1'b0;
        end
    end

    // Advance both lanes
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            wa_reg <= word_a;
            wb_reg <= word_b;
            la_reg <= vcq12_pkg::LEN_W'(vcq12_pkg::VEC_W);
            lb_reg <= vcq12_pkg::LEN_W'(vcq12_pkg::VEC_W);
        end
        else if (run_reg)
        begin
            if (step_a)
            begin
                wa_reg <= wa_reg << 1;
                la_reg <= la_reg - vcq12_pkg::LEN_W'(1);
            end
            if (step_b)
            begin
                wb_reg <= wb_reg << 1;
                lb_reg <= lb_reg - vcq12_pkg::LEN_W'(1);
            end
        end
    end

endmodule

@@ sv/vcq12_isqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcq12_isqrt: serial floor square root of a 32-bit word
// Restoring method, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module vcq12_isqrt (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [vcq12_pkg::VEC_W-1:0]     num,
    output logic                            done,
    output logic [vcq12_pkg::ROOT_W-1:0]    root
);

    localparam int CNT_W = $clog2(vcq12_pkg::VEC_W / 2);

    logic                            run_reg;
    logic                            fin_reg;
    logic [vcq12_pkg::VEC_W-1:0]     num_reg;
    logic [vcq12_pkg::VEC_W-1:0]     res_reg;
    logic [vcq12_pkg::VEC_W-1:0]     bit_reg;
    logic [CNT_W-1:0]                cnt_reg;
    logic [vcq12_pkg::VEC_W-1:0]     trial;
    logic                            take;

    assign trial = res_reg + bit_reg;
    assign take  = num_reg >= trial;
    assign done  = fin_reg;
    assign root  = res_reg[vcq12_pkg::ROOT_W-1:0];

    // Run for one pass of all digit pairs, then pulse done
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            fin_reg <= 1'b0;
        end
        else
        begin
            fin_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
            end
            else if (run_reg && (cnt_reg == {CNT_W{1'b1}}))
            begin
                run_reg <= 1'b0;
                fin_reg <= 1'b1;
            end
        end
    end

    // Develop one root bit per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            res_reg <= '0;
            bit_reg <= vcq12_pkg::VEC_W'(1) << (vcq12_pkg::VEC_W - 2);
            cnt_reg <= '0;
        end
        else if (run_reg)
        begin
            if (take)
            begin
                num_reg <= num_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

endmodule

@@ sv/vcq12_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcq12_div: serial signed divide by the root, with Q12 clamp
// Restoring division of the dividend magnitude, one quotient bit per cycle;
// the quotient truncates toward zero and is clamped to plus or minus 4096.
// ----------------------------------------------------------------------------
module vcq12_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [vcq12_pkg::VEC_W-1:0]     dividend,
    input  logic [vcq12_pkg::ROOT_W-1:0]    divisor,
    output logic                            done,
    output logic [vcq12_pkg::COS_W-1:0]     cosine
);

    localparam int CNT_W = $clog2(vcq12_pkg::VEC_W);
    localparam int MAG_W = vcq12_pkg::COS_W - 1;

    logic                            run_reg;
    logic                            fin_reg;
    logic                            neg_reg;
    logic [vcq12_pkg::ROOT_W-1:0]    div_reg;
    logic [vcq12_pkg::ROOT_W-1:0]    rem_reg;
    logic [vcq12_pkg::VEC_W-1:0]     q_reg;
    logic [CNT_W-1:0]                cnt_reg;
    logic [vcq12_pkg::ROOT_W:0]      trial;
    logic [vcq12_pkg::ROOT_W:0]      diff;
    logic                            ge;
    logic [MAG_W-1:0]                mag;

    assign trial = {rem_reg, q_reg[vcq12_pkg::VEC_W-1]};
    assign diff  = trial - {1'b0, div_reg};
    assign ge    = trial >= {1'b0, div_reg};
    assign done  = fin_reg;

    // Clamp the magnitude, then restore the sign
    assign mag    = (q_reg > vcq12_pkg::VEC_W'(vcq12_pkg::COS_ONE))
                  ? MAG_W'(vcq12_pkg::COS_ONE) : q_reg[MAG_W-1:0];
    assign cosine = neg_reg ? (vcq12_pkg::COS_W'(0) - {1'b0, mag}) : {1'b0, mag};

    // Run for all dividend bits, then pulse done
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            fin_reg <= 1'b0;
        end
        else
        begin
            fin_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
            end
            else if (run_reg && (cnt_reg == {CNT_W{1'b1}}))
            begin
                run_reg <= 1'b0;
                fin_reg <= 1'b1;
            end
        end
    end

    // Shift the dividend out and the quotient in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[vcq12_pkg::VEC_W-1];
            q_reg   <= vcq12_pkg::mag32(dividend);
            div_reg <= divisor;
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? diff[vcq12_pkg::ROOT_W-1:0] : trial[vcq12_pkg::ROOT_W-1:0];
            q_reg   <= {q_reg[vcq12_pkg::VEC_W-2:0], ge};
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

endmodule

@@ sv/vector_cosine_q12_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_cosine_q12_core: Q12 cosine of the angle between two 3D vectors
// Serial bit-length scans, shared 16x16 multiplier, bit-serial balancing,
// norm product, square root and division.
// ----------------------------------------------------------------------------
// Throughput: one transaction at a time; the next is taken once the result
//   has moved to the output register.
// Reset: asynchronous, active low; clears the controller and output valid.
// ----------------------------------------------------------------------------
module vector_cosine_q12_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        operand_valid,
    output logic                        operand_stall,
    input  vcq12_pkg::vcq12_operand_t   operand,
    output logic                        result_valid,
    input  logic                        result_stall,
    output vcq12_pkg::vcq12_result_t    result
);

    localparam int VW  = vcq12_pkg::VEC_W;
    localparam int LW  = vcq12_pkg::LEN_W;
    localparam int CW  = vcq12_pkg::COMP_W;
    localparam int SW  = LW + 1;
    localparam int PCW = $clog2(vcq12_pkg::VEC_W);

    vcq12_pkg::vcq12_state_t    state_reg;
    vcq12_pkg::vcq12_state_t    state_next;

    vcq12_pkg::vcq12_operand_t  op_reg;
    vcq12_pkg::vcq12_result_t   result_reg;
    logic                       result_valid_reg;

    logic signed [CW-1:0]       p_reg [0:2];
    logic signed [CW-1:0]       q_reg [0:2];
    logic [VW-1:0]              sp_reg [0:2];
    logic [VW-1:0]              sq_reg [0:2];
    logic [VW-1:0]              dot_reg [0:2];
    logic [3:0]                 mcnt_reg;
    logic [LW-1:0]              la_reg;
    logic [LW-1:0]              lb_reg;
    logic [LW-1:0]              bal_cnt_reg;
    logic                       bal_left_reg;
    logic [4:0]                 dot_cnt_reg;
    logic                       dot_left_reg;
    logic [VW-1:0]              norm_p_reg;
    logic [VW-1:0]              norm_q_reg;
    logic [VW-1:0]              dsum_reg;
    logic [VW-1:0]              acc_reg;
    logic [PCW-1:0]             pcnt_reg;
    logic signed [vcq12_pkg::COS_W-1:0] cos_res_reg;
    logic                       zd_res_reg;

    logic                       operand_accept;
    logic                       scan_start;
    logic [VW-1:0]              scan_word_a;
    logic [VW-1:0]              scan_word_b;
    logic                       scan_done;
    logic [LW-1:0]              len_a;
    logic [LW-1:0]              len_b;
    logic                       root_start;
    logic                       root_done;
    logic [vcq12_pkg::ROOT_W-1:0] root;
    logic                       div_start;
    logic                       div_done;
    logic [vcq12_pkg::COS_W-1:0] div_cos;
    logic signed [CW-1:0]       mul_a;
    logic signed [CW-1:0]       mul_b;
    logic signed [VW-1:0]       prod;
    logic [SW-1:0]              len_sum;
    logic [SW-1:0]              steps;
    logic [LW-1:0]              bal_init;
    logic                       bal_left_init;
    logic [4:0]                 dot_init;
    logic                       dot_left_init;
    logic                       out_load;

    // Rescale a component to the target bit length
    function automatic logic signed [CW-1:0] rescale(input logic [VW-1:0] v,
                                                     input logic [LW-1:0] len);
        logic [VW-1:0] r;
        begin
            if (len <= LW'(vcq12_pkg::TARGET_LEN))
            begin
                r = v << (LW'(vcq12_pkg::TARGET_LEN) - len);
            end
            else
            begin
                r = $unsigned($signed(v) >>> (len - LW'(vcq12_pkg::TARGET_LEN)));
            end
            return $signed(r[CW-1:0]);
        end
    endfunction

    function automatic logic [VW-1:0] asr1(input logic [VW-1:0] v);
        return {v[VW-1], v[VW-1:1]};
    endfunction

    assign operand_accept = operand_valid && !operand_stall;
    assign operand_stall  = (state_reg != vcq12_pkg::ST_IDLE);
    assign result_valid   = result_valid_reg;
    assign result         = result_reg;
    assign out_load       = (state_reg == vcq12_pkg::ST_DONE)
                         && (!result_valid_reg || !result_stall);

    // Pick scan words: magnitudes on entry, squared vectors later
    always_comb
    begin
        if (state_reg == vcq12_pkg::ST_IDLE)
        begin
            scan_word_a = vcq12_pkg::mag32(operand.first_x)
                        | vcq12_pkg::mag32(operand.first_y)
                        | vcq12_pkg::mag32(operand.first_z);
            scan_word_b = vcq12_pkg::mag32(operand.second_x)
                        | vcq12_pkg::mag32(operand.second_y)
                        | vcq12_pkg::mag32(operand.second_z);
        end
        else
        begin
            scan_word_a = vcq12_pkg::mag32(sp_reg[0]) | vcq12_pkg::mag32(sp_reg[1])
                        | vcq12_pkg::mag32(sp_reg[2]);
            scan_word_b = vcq12_pkg::mag32(sq_reg[0]) | vcq12_pkg::mag32(sq_reg[1])
                        | vcq12_pkg::mag32(sq_reg[2]);
        end
    end

    vcq12_bitlen u_bitlen (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (scan_start),
        .word_a (scan_word_a),
        .word_b (scan_word_b),
        .done   (scan_done),
        .len_a  (len_a),
        .len_b  (len_b)
    );

    vcq12_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (root_start),
        .num   (acc_reg),
        .done  (root_done),
        .root  (root)
    );

    vcq12_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dsum_reg),
        .divisor  (root),
        .done     (div_done),
        .cosine   (div_cos)
    );

    // Select multiplier operands: squares of each vector, then the dot terms
    always_comb
    begin
        case (mcnt_reg)
            4'd0:    begin mul_a = p_reg[0]; mul_b = p_reg[0]; end
            4'd1:    begin mul_a = p_reg[1]; mul_b = p_reg[1]; end
            4'd2:    begin mul_a = p_reg[2]; mul_b = p_reg[2]; end
            4'd3:    begin mul_a = q_reg[0]; mul_b = q_reg[0]; end
            4'd4:    begin mul_a = q_reg[1]; mul_b = q_reg[1]; end
            4'd5:    begin mul_a = q_reg[2]; mul_b = q_reg[2]; end
            4'd6:    begin mul_a = p_reg[0]; mul_b = q_reg[0]; end
            4'd7:    begin mul_a = p_reg[1]; mul_b = q_reg[1]; end
            4'd8:    begin mul_a = p_reg[2]; mul_b = q_reg[2]; end
            default: begin mul_a = '0;       mul_b = '0;       end
        endcase
    end

    // Sign-extend before multiplying so the full product is kept
    assign prod = VW'(mul_a) * VW'(mul_b);

    // Work out balancing and dot shift counts from the squared bit lengths
    always_comb
    begin
        len_sum       = SW'(len_a) + SW'(len_b);
        steps         = '0;
        bal_init      = '0;
        bal_left_init = 1'b1;
        dot_init      = 5'(vcq12_pkg::Q_SHIFT);
        dot_left_init = 1'b1;
        if (len_sum < SW'(vcq12_pkg::BAL_TOTAL))
        begin
            bal_init = LW'((SW'(vcq12_pkg::BAL_TOTAL + 1) - len_sum) >> 1);
            dot_init = 5'(bal_init) + 5'(vcq12_pkg::Q_SHIFT);
        end
        else if (len_sum > SW'(vcq12_pkg::BAL_TOTAL))
        begin
            steps         = (len_sum - SW'(vcq12_pkg::BAL_TOTAL - 1)) & ~SW'(1);
            bal_init      = LW'(steps);
            bal_left_init = 1'b0;
            if ((steps >> 1) <= SW'(vcq12_pkg::Q_SHIFT))
            begin
                dot_init = 5'(SW'(vcq12_pkg::Q_SHIFT) - (steps >> 1));
            end
            else
            begin
                dot_init      = 5'((steps >> 1) - SW'(vcq12_pkg::Q_SHIFT));
                dot_left_init = 1'b0;
            end
        end
    end

    // Hold the controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vcq12_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and unit strobes
    always_comb
    begin
        state_next = state_reg;
        scan_start = 1'b0;
        root_start = 1'b0;
        div_start  = 1'b0;
        case (state_reg)
            vcq12_pkg::ST_IDLE:
            begin
                if (operand_accept)
                begin
                    scan_start = 1'b1;
                    state_next = vcq12_pkg::ST_SCAN1;
                end
            end
            vcq12_pkg::ST_SCAN1:
            begin
                if (scan_done)
                begin
                    state_next = vcq12_pkg::ST_MUL;
                end
            end
            vcq12_pkg::ST_MUL:
            begin
                if (mcnt_reg == 4'd8)
                begin
                    state_next = vcq12_pkg::ST_SCAN2_GO;
                end
            end
            vcq12_pkg::ST_SCAN2_GO:
            begin
                scan_start = 1'b1;
                state_next = vcq12_pkg::ST_SCAN2;
            end
            vcq12_pkg::ST_SCAN2:
            begin
                if (scan_done)
                begin
                    state_next = vcq12_pkg::ST_BAL;
                end
            end
            vcq12_pkg::ST_BAL:
            begin
                if ((bal_cnt_reg == '0) && (dot_cnt_reg == '0))
                begin
                    state_next = vcq12_pkg::ST_SUM;
                end
            end
            vcq12_pkg::ST_SUM:
            begin
                state_next = vcq12_pkg::ST_NPROD;
            end
            vcq12_pkg::ST_NPROD:
            begin
                if (pcnt_reg == {PCW{1'b1}})
                begin
                    state_next = vcq12_pkg::ST_ROOT_GO;
                end
            end
            vcq12_pkg::ST_ROOT_GO:
            begin
                root_start = 1'b1;
                state_next = vcq12_pkg::ST_SQRT;
            end
            vcq12_pkg::ST_SQRT:
            begin
                if (root_done)
                begin
                    if (root == '0)
                    begin
                        state_next = vcq12_pkg::ST_DONE;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = vcq12_pkg::ST_DIV;
                    end
                end
            end
            vcq12_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = vcq12_pkg::ST_DONE;
                end
            end
            vcq12_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = vcq12_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = vcq12_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            vcq12_pkg::ST_IDLE:
            begin
                if (operand_accept)
                begin
                    op_reg <= operand;
                end
            end
            vcq12_pkg::ST_SCAN1:
            begin
                if (scan_done)
                begin
                    p_reg[0] <= rescale(op_reg.first_x, len_a);
                    p_reg[1] <= rescale(op_reg.first_y, len_a);
                    p_reg[2] <= rescale(op_reg.first_z, len_a);
                    q_reg[0] <= rescale(op_reg.second_x, len_b);
                    q_reg[1] <= rescale(op_reg.second_y, len_b);
                    q_reg[2] <= rescale(op_reg.second_z, len_b);
                    mcnt_reg <= '0;
                end
            end
            vcq12_pkg::ST_MUL:
            begin
                case (mcnt_reg)
                    4'd0:    sp_reg[0]  <= prod;
                    4'd1:    sp_reg[1]  <= prod;
                    4'd2:    sp_reg[2]  <= prod;
                    4'd3:    sq_reg[0]  <= prod;
                    4'd4:    sq_reg[1]  <= prod;
                    4'd5:    sq_reg[2]  <= prod;
                    4'd6:    dot_reg[0] <= prod;
                    4'd7:    dot_reg[1] <= prod;
                    4'd8:    dot_reg[2] <= prod;
                    default: ;
                endcase
                mcnt_reg <= mcnt_reg + 4'd1;
            end
            vcq12_pkg::ST_SCAN2:
            begin
                if (scan_done)
                begin
                    la_reg       <= len_a;
                    lb_reg       <= len_b;
                    bal_cnt_reg  <= bal_init;
                    bal_left_reg <= bal_left_init;
                    dot_cnt_reg  <= dot_init;
                    dot_left_reg <= dot_left_init;
                end
            end
            vcq12_pkg::ST_BAL:
            begin
                // Balance the squared pair one bit per cycle
                if (bal_cnt_reg != '0)
                begin
                    if (bal_left_reg)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            sp_reg[i] <= sp_reg[i] << 1;
                            sq_reg[i] <= sq_reg[i] << 1;
                        end
                    end
                    else if (la_reg < lb_reg)
                    begin
                        lb_reg <= lb_reg - LW'(1);
                        for (int i = 0; i < 3; i++)
                        begin
                            sq_reg[i] <= asr1(sq_reg[i]);
                        end
                    end
                    else
                    begin
                        la_reg <= la_reg - LW'(1);
                        for (int i = 0; i < 3; i++)
                        begin
                            sp_reg[i] <= asr1(sp_reg[i]);
                        end
                    end
                    bal_cnt_reg <= bal_cnt_reg - LW'(1);
                end
                // Shift the dot terms alongside
                if (dot_cnt_reg != '0)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        dot_reg[i] <= dot_left_reg ? (dot_reg[i] << 1) : asr1(dot_reg[i]);
                    end
                    dot_cnt_reg <= dot_cnt_reg - 5'd1;
                end
            end
            vcq12_pkg::ST_SUM:
            begin
                norm_p_reg <= sp_reg[0] + sp_reg[1] + sp_reg[2];
                norm_q_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2];
                dsum_reg   <= dot_reg[0] + dot_reg[1] + dot_reg[2];
                acc_reg    <= '0;
                pcnt_reg   <= '0;
            end
            vcq12_pkg::ST_NPROD:
            begin
                // Shift-add product of the norms, wrapping at 32 bits
                acc_reg    <= acc_reg + (norm_q_reg[0] ? norm_p_reg : '0);
                norm_p_reg <= norm_p_reg << 1;
                norm_q_reg <= norm_q_reg >> 1;
                pcnt_reg   <= pcnt_reg + PCW'(1);
            end
            vcq12_pkg::ST_SQRT:
            begin
                if (root_done && (root == '0))
                begin
                    cos_res_reg <= '0;
                    zd_res_reg  <= 1'b1;
                end
            end
            vcq12_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    cos_res_reg <= $signed(div_cos);
                    zd_res_reg  <= 1'b0;
                end
            end
            default: ;
        endcase
    end

    // Output register: load when free, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            result_reg.cosine       <= cos_res_reg;
            result_reg.zero_divisor <= zd_res_reg;
        end
    end

    // Checks
    a_zero_div_cos: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.zero_divisor) |-> (result_reg.cosine == '0))
        else $error("zero divisor result with nonzero cosine");

    a_cos_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (($signed(result_reg.cosine) <= $signed(14'sd4096))
                           && ($signed(result_reg.cosine) >= $signed(-14'sd4096))))
        else $error("cosine outside clamp range");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        operand_accept |=> (state_reg != vcq12_pkg::ST_IDLE))
        else $error("controller idle after accepting a transaction");

    a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> ($past(state_reg) == vcq12_pkg::ST_DONE))
        else $error("result raised outside completion");

    a_bal_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == vcq12_pkg::ST_BAL) |-> ((la_reg != '0) && (lb_reg != '0)))
        else $error("balancing length counter reached zero");

endmodule
